### sv/rpts_pkg.sv
// Shared types and constants for the rotating priority task select unit.
// Used by every module of the block but rpts_ram; depends on nothing.
package rpts_pkg;

  // Default table size and fixed field widths
  localparam int SLOT_COUNT_DEF = 64;
  localparam int SLOT_W         = 6;
  localparam int PRI_W          = 8;
  localparam int TOTAL_W        = 31;

  // Marker priority above every real priority (no pick yet)
  localparam int PRIORITY_NONE  = 256;

  // Command queue between front and back
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SELECT = 1'b1
  } op_t;

  // One input word
  typedef struct packed {
    op_t               operation;
    logic [SLOT_W-1:0] slot;
    logic              runnable;
    logic              loaded;
    logic [PRI_W-1:0]  priority_req;
  } in_item_t;

  // One result word
  typedef struct packed {
    logic               found;
    logic [SLOT_W-1:0]  chosen_slot;
    logic [PRI_W-1:0]   chosen_priority;
    logic [TOTAL_W-1:0] switch_total;
  } out_item_t;

  // One slot table entry as stored in the RAM
  typedef struct packed {
    logic             runnable;
    logic             loaded;
    logic [PRI_W-1:0] priority_val;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Classified command held in the queue
  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    entry_t            entry;
  } cmd_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FINISH
  } bk_state_t;

endpackage

### sv/rpts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the slot table; no dependencies.
module rpts_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/rpts_front.sv
// Front end: takes input words, classifies them and pushes commands.
// Depends on rpts_pkg; feeds rpts_queue.
module rpts_front
  import rpts_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  in_item_t  in_item,
  input  logic      start,
  input  q_status_t q_stat,
  output logic      busy,
  output logic      push,
  output cmd_t      cmd
);

  logic accept;
  logic in_range;
  logic keep;

  // Hold off new words only while the queue is full
  assign busy   = q_stat.full;
  assign accept = start && !busy;

  // Drop writes aimed past the end of the table
  assign in_range = (9'(in_item.slot) < 9'(SLOT_COUNT));
  assign keep     = (in_item.operation == OP_SELECT) || in_range;
  assign push     = accept && keep;

  // Build the command word
  always_comb begin
    cmd.op                 = in_item.operation;
    cmd.slot               = in_item.slot;
    cmd.entry.runnable     = in_item.runnable;
    cmd.entry.loaded       = in_item.loaded;
    cmd.entry.priority_val = in_item.priority_req;
  end

endmodule

### sv/rpts_queue.sv
// Short command queue between front and back end.
// Depends on rpts_pkg.
module rpts_queue
  import rpts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t q_stat
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_ptr_r];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

### sv/rpts_back.sv
// Back end: applies slot writes and runs the rotating priority scan.
// Depends on rpts_pkg and rpts_ram; drains rpts_queue.
module rpts_back
  import rpts_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_t      head,
  input  q_status_t q_stat,
  output logic      pop,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  bk_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]   last_r, last_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]   issue_cnt_r, issue_cnt_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic               cmp_written_r;
  logic [PRI_W:0]     best_pri_r, best_pri_nxt;
  logic [IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;
  logic [SLOT_COUNT-1:0] written_r;

  logic               ram_we;
  logic [IDX_W-1:0]   wr_idx;
  entry_t             rd_entry;
  logic               eligible;
  logic               found;
  logic [TOTAL_W-1:0] total_inc;

  // Next slot in rotation order
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    if (i == IDX_W'(SLOT_COUNT - 1)) begin
      return '0;
    end
    return i + IDX_W'(1);
  endfunction

  assign wr_idx = IDX_W'(head.slot);

  rpts_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SLOT_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_idx),
    .wdata(head.entry),
    .raddr(rd_idx_r),
    .rdata(rd_entry)
  );

  // Slot eligible when written, runnable, loaded and strictly better
  assign eligible = cmp_vld_r && cmp_written_r && rd_entry.runnable && rd_entry.loaded
                    && ({1'b0, rd_entry.priority_val} < best_pri_r);
  assign found     = !best_pri_r[PRI_W];
  assign total_inc = (&total_r) ? '0 : total_r + TOTAL_W'(1);

  // Sequencer: next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    total_nxt     = total_r;
    rd_idx_nxt    = rd_idx_r;
    issue_cnt_nxt = issue_cnt_r;
    cmp_vld_nxt   = 1'b0;
    best_pri_nxt  = best_pri_r;
    best_idx_nxt  = best_idx_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          if (head.op == OP_SELECT) begin
            rd_idx_nxt    = next_idx(last_r);
            issue_cnt_nxt = '0;
            best_pri_nxt  = (PRI_W + 1)'(PRIORITY_NONE);
            best_idx_nxt  = '0;
            state_nxt     = BK_SCAN;
          end else begin
            ram_we = 1'b1;
          end
        end
      end
      BK_SCAN: begin
        // Issue one table read a cycle, compare the one that returned
        if (issue_cnt_r != CNT_W'(SLOT_COUNT)) begin
          rd_idx_nxt    = next_idx(rd_idx_r);
          issue_cnt_nxt = issue_cnt_r + CNT_W'(1);
          cmp_vld_nxt   = 1'b1;
        end else begin
          state_nxt = BK_FINISH;
        end
        if (eligible) begin
          best_pri_nxt = {1'b0, rd_entry.priority_val};
          best_idx_nxt = cmp_idx_r;
        end
      end
      BK_FINISH: begin
        out_valid_nxt = 1'b1;
        if (found) begin
          total_nxt                    = total_inc;
          last_nxt                     = best_idx_r;
          out_item_nxt.found           = 1'b1;
          out_item_nxt.chosen_slot     = SLOT_W'(best_idx_r);
          out_item_nxt.chosen_priority = best_pri_r[PRI_W-1:0];
          out_item_nxt.switch_total    = total_inc;
        end else begin
          out_item_nxt.found           = 1'b0;
          out_item_nxt.chosen_slot     = '0;
          out_item_nxt.chosen_priority = '0;
          out_item_nxt.switch_total    = total_r;
        end
        state_nxt = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // Control state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      last_r      <= '0;
      total_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_item_r  <= '0;
      written_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      total_r     <= total_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
      out_item_r  <= out_item_nxt;
      if (ram_we) begin
        written_r[wr_idx] <= 1'b1;
      end
    end
  end

  // Scan datapath; track index and written bit alongside the RAM read
  always_ff @(posedge clk) begin
    rd_idx_r      <= rd_idx_nxt;
    issue_cnt_r   <= issue_cnt_nxt;
    best_pri_r    <= best_pri_nxt;
    best_idx_r    <= best_idx_nxt;
    cmp_idx_r     <= rd_idx_r;
    cmp_written_r <= written_r[rd_idx_r];
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### sv/rotating_priority_task_select_unit.sv
// Rotating priority task select unit: top level.
// Depends on rpts_pkg, rpts_front, rpts_queue and rpts_back.
//
// A word is taken when start is high and busy is low; a two-entry command
// queue sits behind the input, so busy only rises when that queue is full.
// A word that reaches an empty queue with the back end idle leaves the queue
// in the cycle after it is taken. A write word updates one slot in the cycle
// it leaves the queue and gives no result; a write to a slot at or past
// SLOT_COUNT is dropped. A select word leaves the queue in a dispatch state,
// then the back end scans the table (one table RAM read issued per cycle, the
// last read compared once it returns) and makes its decision; it pops no
// further word until then. Its result shows in the cycle after the decision.
// The result is shown for one cycle with out_valid high and cannot be held
// off by the receiver. The table comes out of reset empty through per-slot
// written bits, so no clearing pass runs after reset.
module rotating_priority_task_select_unit
  import rpts_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  logic      push;
  cmd_t      push_cmd;
  logic      pop;
  cmd_t      head;
  q_status_t q_stat;

  rpts_front #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_front (
    .in_item(in_item),
    .start  (start),
    .q_stat (q_stat),
    .busy   (busy),
    .push   (push),
    .cmd    (push_cmd)
  );

  rpts_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .q_stat  (q_stat)
  );

  rpts_back #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_valid(out_valid),
    .out_item (out_item)
  );

endmodule

### sv/rpts_checker.sv
// Port-level checks for the rotating priority task select unit.
// Depends on rpts_pkg; bound to the top level at the end of this file.
module rpts_checker
  import rpts_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_item
);

  // Come out of reset quiet and ready
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("output or busy active right after reset");

  // Each result needs a full scan, so results never come back to back
  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  // A miss reports zero slot and priority
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.found |->
      out_item.chosen_slot == '0 && out_item.chosen_priority == '0)
    else $error("miss result carries a slot or priority");

  // A miss repeats the switch total of the word held from the last result
  a_total_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.found && $past(rst_n) |->
      out_item.switch_total == $past(out_item.switch_total))
    else $error("switch total changed on a miss");

endmodule

bind rotating_priority_task_select_unit rpts_checker u_rpts_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_item  (in_item),
  .out_valid(out_valid),
  .out_item (out_item)
);

### verif/testbench.sv
// Self-checking testbench for rotating_priority_task_select_unit.
// Depends on rpts_pkg and the RTL: a directed table, then random traffic
// under several idling phases; results match a typed pick or a local predictor.
module testbench;
  import rpts_pkg::*;

  localparam int SLOTS        = SLOT_COUNT_DEF;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 2 * SLOTS + 20;
  localparam int DIR_ROWS     = 24;
  localparam int PHASE_WORDS  = 410;
  localparam int BLOCK_WORDS  = 41;

  typedef struct {
    in_item_t  word;
    bit        typed;
    out_item_t pick;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  // Predictor state: slot table, rotation pointer, current priority, switch count
  entry_t             slot_model [SLOTS];
  logic [SLOT_W-1:0]  last_pick;
  logic [PRI_W-1:0]   cur_pri;
  logic [TOTAL_W-1:0] switch_cnt;

  out_item_t pending_picks [$];
  dir_row_t  dir_rows [DIR_ROWS];
  // Sender idle percentage per phase; the receiver cannot stall, so the
  // receiver-stall phase runs the sender flat out
  int phase_idle [4] = '{0, 51, 0, 11};
  int idle_pct;
  int fail_cnt;
  int word_cnt;
  int select_cnt;
  int pick_cnt;
  int empty_cnt;
  int cycle_cnt;

  rotating_priority_task_select_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Clock: period 10
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic in_item_t word_of(op_t op, int slot, bit run, bit ld, int pri);
    in_item_t w;
    w.operation    = op;
    w.slot         = SLOT_W'(slot);
    w.runnable     = run;
    w.loaded       = ld;
    w.priority_req = PRI_W'(pri);
    return w;
  endfunction

  function automatic out_item_t pick_of(bit found, int slot, int pri, int total);
    out_item_t p;
    p.found           = found;
    p.chosen_slot     = SLOT_W'(slot);
    p.chosen_priority = PRI_W'(pri);
    p.switch_total    = TOTAL_W'(total);
    return p;
  endfunction

  // Scan the table once in rotation after the last pick; lowest priority wins,
  // first in rotation on a tie. Advance the state only on a successful pick.
  function automatic out_item_t predict_pick();
    out_item_t          p;
    int                 best_pri;
    int                 best;
    int                 idx;
    logic [TOTAL_W:0]   next_cnt;
    best_pri = PRIORITY_NONE;
    best     = -1;
    for (int c = 0; c < SLOTS; c++) begin
      idx = (int'(last_pick) + 1 + c) % SLOTS;
      if (slot_model[idx].runnable && slot_model[idx].loaded &&
          int'(slot_model[idx].priority_val) < best_pri) begin
        best_pri = int'(slot_model[idx].priority_val);
        best     = idx;
      end
    end
    p = '0;
    p.switch_total = switch_cnt;
    if (best >= 0) begin
      // Wrap the counter to zero once the increment reaches bit 31
      next_cnt   = {1'b0, switch_cnt} + 1'b1;
      switch_cnt = next_cnt[TOTAL_W] ? '0 : next_cnt[TOTAL_W-1:0];
      cur_pri    = PRI_W'(best_pri);
      last_pick  = SLOT_W'(best);
      p.found           = 1'b1;
      p.chosen_slot     = last_pick;
      p.chosen_priority = cur_pri;
      p.switch_total    = switch_cnt;
    end
    return p;
  endfunction

  // Random word; elig_pct sets how often a write makes its slot eligible,
  // pri_span narrows priorities to force ties
  function automatic in_item_t rand_word(int elig_pct, int pri_span);
    in_item_t   w;
    logic [1:0] rl;
    w = in_item_t'($bits(in_item_t)'($urandom));
    w.operation = ($urandom_range(99) < 35) ? OP_SELECT : OP_WRITE;
    if ($urandom_range(99) < elig_pct) begin
      w.runnable = 1'b1;
      w.loaded   = 1'b1;
    end else begin
      rl = 2'($urandom_range(2));
      w.runnable = rl[1];
      w.loaded   = rl[0];
    end
    w.priority_req = PRI_W'($urandom_range(pri_span - 1));
    return w;
  endfunction

  // Drive one word at the falling edge, hold it until taken, then update the model or predict
  task automatic send_word(in_item_t w, bit typed, out_item_t typed_pick);
    out_item_t p;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= w;
    do @(posedge clk); while (busy);
    word_cnt++;
    if (w.operation == OP_WRITE) begin
      if (int'(w.slot) < SLOTS)
        slot_model[w.slot] = '{w.runnable, w.loaded, w.priority_req};
    end else begin
      p = predict_pick();
      select_cnt++;
      pending_picks.push_back(typed ? typed_pick : p);
    end
  endtask

  // Check each result word against the oldest pending pick
  always @(posedge clk) begin
    out_item_t exp_pick;
    if (rst_n && out_valid) begin
      pick_cnt++;
      if (pending_picks.size() == 0) begin
        $error("result word with no select pending: %p", out_item);
        fail_cnt++;
      end else begin
        exp_pick = pending_picks.pop_front();
        if (!exp_pick.found)
          empty_cnt++;
        if (out_item.found !== exp_pick.found) begin
          $error("found: expected %0d, got %0d", exp_pick.found, out_item.found);
          fail_cnt++;
        end
        if (out_item.chosen_slot !== exp_pick.chosen_slot) begin
          $error("chosen_slot: expected %0d, got %0d",
                 exp_pick.chosen_slot, out_item.chosen_slot);
          fail_cnt++;
        end
        if (out_item.chosen_priority !== exp_pick.chosen_priority) begin
          $error("chosen_priority: expected %0d, got %0d",
                 exp_pick.chosen_priority, out_item.chosen_priority);
          fail_cnt++;
        end
        if (out_item.switch_total !== exp_pick.switch_total) begin
          $error("switch_total: expected %0d, got %0d",
                 exp_pick.switch_total, out_item.switch_total);
          fail_cnt++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $error("run stopped after %0d cycles, %0d picks still pending",
             cycle_cnt, pending_picks.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int elig_pct;
    int pri_span;
    in_item_t w;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    idle_pct   = 0;
    fail_cnt   = 0;
    word_cnt   = 0;
    select_cnt = 0;
    pick_cnt   = 0;
    empty_cnt  = 0;
    cycle_cnt  = 0;
    elig_pct   = 0;
    pri_span   = 256;
    foreach (slot_model[i])
      slot_model[i] = '0;
    last_pick  = '0;
    cur_pri    = '0;
    switch_cnt = '0;

    // Directed table: empty table, ineligible slots, extremes, ties in
    // rotation, ignored fields on a select, not found after a pick
    dir_rows[0]  = '{word_of(OP_SELECT, 0, 0, 0, 0), 1'b1, pick_of(0, 0, 0, 0)};
    dir_rows[1]  = '{word_of(OP_WRITE, 0, 1, 0, 5), 1'b0, '0};
    dir_rows[2]  = '{word_of(OP_WRITE, 1, 0, 1, 7), 1'b0, '0};
    dir_rows[3]  = '{word_of(OP_SELECT, 0, 0, 0, 0), 1'b1, pick_of(0, 0, 0, 0)};
    dir_rows[4]  = '{word_of(OP_WRITE, 63, 1, 1, 255), 1'b0, '0};
    dir_rows[5]  = '{word_of(OP_SELECT, 0, 0, 0, 0), 1'b1, pick_of(1, 63, 255, 1)};
    dir_rows[6]  = '{word_of(OP_WRITE, 0, 1, 1, 0), 1'b0, '0};
    dir_rows[7]  = '{word_of(OP_SELECT, 0, 0, 0, 0), 1'b1, pick_of(1, 0, 0, 2)};
    dir_rows[8]  = '{word_of(OP_WRITE, 10, 1, 1, 0), 1'b0, '0};
    dir_rows[9]  = '{word_of(OP_WRITE, 20, 1, 1, 0), 1'b0, '0};
    dir_rows[10] = '{word_of(OP_SELECT, 0, 0, 0, 0), 1'b1, pick_of(1, 10, 0, 3)};
    dir_rows[11] = '{word_of(OP_SELECT, 0, 0, 0, 0), 1'b1, pick_of(1, 20, 0, 4)};
    dir_rows[12] = '{word_of(OP_SELECT, 0, 0, 0, 0), 1'b1, pick_of(1, 0, 0, 5)};
    dir_rows[13] = '{word_of(OP_WRITE, 0, 0, 1, 0), 1'b0, '0};
    dir_rows[14] = '{word_of(OP_SELECT, 0, 0, 0, 0), 1'b1, pick_of(1, 10, 0, 6)};
    dir_rows[15] = '{word_of(OP_SELECT, 63, 1, 1, 255), 1'b0, '0};
    dir_rows[16] = '{word_of(OP_WRITE, 20, 1, 1, 200), 1'b0, '0};
    dir_rows[17] = '{word_of(OP_SELECT, 0, 0, 0, 0), 1'b0, '0};
    dir_rows[18] = '{word_of(OP_WRITE, 63, 1, 1, 255), 1'b0, '0};
    dir_rows[19] = '{word_of(OP_WRITE, 10, 0, 0, 0), 1'b0, '0};
    dir_rows[20] = '{word_of(OP_WRITE, 20, 0, 0, 0), 1'b0, '0};
    dir_rows[21] = '{word_of(OP_SELECT, 0, 0, 0, 0), 1'b1, pick_of(1, 63, 255, 9)};
    dir_rows[22] = '{word_of(OP_WRITE, 63, 0, 0, 0), 1'b0, '0};
    dir_rows[23] = '{word_of(OP_SELECT, 0, 0, 0, 0), 1'b1, pick_of(0, 0, 0, 9)};

    // Hold reset, then release it at a falling edge
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].pick);

    foreach (phase_idle[ph]) begin
      idle_pct = phase_idle[ph];
      // Drain the table, then confirm nothing is eligible
      for (int s = 0; s < SLOTS; s++) begin
        w = rand_word(0, 256);
        w.operation = OP_WRITE;
        w.slot      = SLOT_W'(s);
        send_word(w, 1'b0, '0);
      end
      w = rand_word(0, 256);
      w.operation = OP_SELECT;
      send_word(w, 1'b0, '0);
      // Random traffic in blocks with their own eligibility and priority spread
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n % BLOCK_WORDS == 0) begin
          elig_pct = $urandom_range(100);
          pri_span = $urandom_range(1) ? 4 : 256;
        end
        send_word(rand_word(elig_pct, pri_span), 1'b0, '0);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words (%0d selects) over %0d idling phases after the directed table.",
             word_cnt, select_cnt, $size(phase_idle));
    $display("Checked %0d result words, %0d of them with no eligible slot.",
             pick_cnt, empty_cnt);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
